// ===== sv/half_length_common_substring_test_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the half-length common substring test
// Shared property shorthands used by the checker of this block.
// ---------------------------------------------------------------------------
`ifndef HALF_LENGTH_COMMON_SUBSTRING_TEST_MACROS_SVH
`define HALF_LENGTH_COMMON_SUBSTRING_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HLCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hlcs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hlcs_pkg
// Beat types, cell control and verdict codes of the common substring test.
// ---------------------------------------------------------------------------
package hlcs_pkg;

    // Verdict codes carried in the result beat.
    localparam logic [1:0] VERDICT_SIMILAR    = 2'd0;
    localparam logic [1:0] VERDICT_DISSIMILAR = 2'd1;
    localparam logic [1:0] VERDICT_TOO_SHORT  = 2'd2;

    // One input beat: a character (or end marker) of one of the two names.
    typedef struct packed {
        logic       name_select;
        logic       has_char;
        logic [7:0] char_code;
        logic       end_of_name;
    } t_in_beat;

    // One result beat, given after the end of the second name.
    typedef struct packed {
        logic [1:0] verdict;
        logic [8:0] common_run;
        logic       truncated;
    } t_out_beat;

    // Control that the sequencer broadcasts to every cell of the chain.
    typedef struct packed {
        logic load;     // shift a first-name character into the chain
        logic clear;    // drop the stored first name
        logic clr_run;  // zero run lengths and local best values
        logic cmp;      // match one second-name character against the chain
        logic drain;    // move best values one cell toward the head
    } t_cell_ctl;

endpackage

// ===== sv/hlcs_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hlcs_cell
// One position of the first name: its character, the common run ending
// there and the best run seen, exchanged with both neighbors.
// ---------------------------------------------------------------------------
module hlcs_cell #(
    parameter int RUN_W = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hlcs_pkg::t_cell_ctl  i_ctl,
    input  logic [7:0]           i_char,
    input  logic                 i_left_valid,
    input  logic [7:0]           i_left_char,
    input  logic [RUN_W-1:0]     i_right_run,
    input  logic [RUN_W-1:0]     i_right_best,
    output logic                 o_valid,
    output logic [7:0]           o_char,
    output logic [RUN_W-1:0]     o_run,
    output logic [RUN_W-1:0]     o_best
);

    logic             r_valid;
    logic             n_valid;
    logic [7:0]       r_char;
    logic [7:0]       n_char;
    logic [RUN_W-1:0] r_run;
    logic [RUN_W-1:0] n_run;
    logic [RUN_W-1:0] r_best;
    logic [RUN_W-1:0] n_best;
    logic             w_match;
    logic [RUN_W-1:0] w_run_cmp;

    // A run extends the one that ended at the previous first-name position.
    assign w_match   = r_valid && (r_char == i_char);
    assign w_run_cmp = w_match ? RUN_W'(i_right_run + RUN_W'(1)) : '0;

    // Next-state selection for the stored character, valid bit, run and best value.
    always_comb begin
        n_valid = r_valid;
        n_char  = r_char;
        n_run   = r_run;
        n_best  = r_best;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end
        if (i_ctl.load) begin
            n_valid = i_left_valid;
            n_char  = i_left_char;
        end
        if (i_ctl.clr_run) begin
            n_run  = '0;
            n_best = '0;
        end else if (i_ctl.cmp) begin
            n_run  = w_run_cmp;
            n_best = (w_run_cmp > r_best) ? w_run_cmp : r_best;
        end else if (i_ctl.drain) begin
            n_best = (i_right_best > r_best) ? i_right_best : r_best;
        end
    end

    // Valid bit is control state and resets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload registers are always written before they are read.
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_run  <= n_run;
        r_best <= n_best;
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_run   = r_run;
    assign o_best  = r_best;

endmodule

// ===== sv/half_length_common_substring_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// half_length_common_substring_test
// Streams two names through a chain of character cells and reports whether
// their longest common substring reaches half of the longer length.
// ---------------------------------------------------------------------------
//   Channel   Ports                       Handshake
//   input     start, busy, i_in           beat taken when start & !busy
//   result    o_strobe, o_result          beat shown for one cycle only
//
// A first-name or second-name beat is taken whenever the block is not busy.
// The last beat of the second name is followed by busy states: ST_DRAIN
// moves best values down the cell chain, one cell a cycle, and ST_DONE
// forms the verdict; the result strobe follows.
// Reset clears the cell valid bits and the sequencer.
// The receiver cannot stall; a result beat is never held.
// ---------------------------------------------------------------------------
module half_length_common_substring_test #(
    parameter int MAX_LEN = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  hlcs_pkg::t_in_beat   i_in,
    output logic                 o_strobe,
    output hlcs_pkg::t_out_beat  o_result
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(MAX_LEN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [LW-1:0]       r_first_len;
    logic [LW-1:0]       r_second_len;
    logic                r_overflow;
    logic                r_loading;
    logic [CW-1:0]       r_drain_cnt;
    logic                r_strobe;
    hlcs_pkg::t_out_beat r_result;

    logic                w_accept;
    logic                w_sel_first;
    logic                w_sel_second;
    logic                w_abandon;
    logic [LW-1:0]       w_first_cur;
    logic                w_first_room;
    logic                w_second_room;
    hlcs_pkg::t_cell_ctl w_ctl;

    logic                w_valid [MAX_LEN];
    logic [7:0]          w_char  [MAX_LEN];
    logic [LW-1:0]       w_run   [MAX_LEN];
    logic [LW-1:0]       w_best  [MAX_LEN];

    logic [LW-1:0]       w_shorter;
    logic [LW-1:0]       w_longer;
    logic [LW:0]         w_half;
    logic [1:0]          w_verdict;

    // Beat acceptance and decoding.
    assign busy          = (r_state != ST_IDLE);
    assign w_accept      = start && !busy;
    assign w_sel_first   = w_accept && !i_in.name_select;
    assign w_sel_second  = w_accept && i_in.name_select && r_loading;
    assign w_abandon     = w_sel_first && r_loading;
    assign w_first_cur   = w_abandon ? '0 : r_first_len;
    assign w_first_room  = (w_first_cur < LW'(MAX_LEN));
    assign w_second_room = (r_second_len < LW'(MAX_LEN));

    // Control broadcast to the cell chain.
    always_comb begin
        w_ctl.clear   = w_abandon || (r_state == ST_DONE);
        w_ctl.load    = w_sel_first && i_in.has_char && w_first_room;
        w_ctl.clr_run = w_sel_first && i_in.end_of_name;
        w_ctl.cmp     = w_sel_second && i_in.has_char && w_second_room;
        w_ctl.drain   = (r_state == ST_DRAIN);
    end

    // The chain: characters enter at cell 0, so a cell's predecessor in the
    // first name sits to its right, and runs and best values come from there.
    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        logic          w_left_valid;
        logic [7:0]    w_left_char;
        logic [LW-1:0] w_right_run;
        logic [LW-1:0] w_right_best;

        if (j == 0) begin : g_head
            assign w_left_valid = 1'b1;
            assign w_left_char  = i_in.char_code;
        end else begin : g_body
            assign w_left_valid = w_valid[j-1] && !w_ctl.clear;
            assign w_left_char  = w_char[j-1];
        end

        if (j == MAX_LEN - 1) begin : g_tail
            assign w_right_run  = '0;
            assign w_right_best = '0;
        end else begin : g_inner
            assign w_right_run  = w_run[j+1];
            assign w_right_best = w_best[j+1];
        end

        hlcs_cell #(
            .RUN_W (LW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_char       (i_in.char_code),
            .i_left_valid (w_left_valid),
            .i_left_char  (w_left_char),
            .i_right_run  (w_right_run),
            .i_right_best (w_right_best),
            .o_valid      (w_valid[j]),
            .o_char       (w_char[j]),
            .o_run        (w_run[j]),
            .o_best       (w_best[j])
        );
    end

    // Verdict from the lengths and the best run collected at the head cell.
    always_comb begin
        w_shorter = (r_first_len < r_second_len) ? r_first_len : r_second_len;
        w_longer  = (r_first_len < r_second_len) ? r_second_len : r_first_len;
        w_half    = ({1'b0, w_longer} + (LW + 1)'(1)) >> 1;
        if ((r_first_len == r_second_len) && (w_best[0] == r_first_len)) begin
            w_verdict = hlcs_pkg::VERDICT_SIMILAR;
        end else if (w_half > {1'b0, w_shorter}) begin
            w_verdict = hlcs_pkg::VERDICT_TOO_SHORT;
        end else if ({1'b0, w_best[0]} >= w_half) begin
            w_verdict = hlcs_pkg::VERDICT_SIMILAR;
        end else begin
            w_verdict = hlcs_pkg::VERDICT_DISSIMILAR;
        end
    end

    // Sequencer: lengths, flags, drain count and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_first_len  <= '0;
            r_second_len <= '0;
            r_overflow   <= 1'b0;
            r_loading    <= 1'b0;
            r_drain_cnt  <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_sel_first) begin
                        r_first_len  <= w_ctl.load ? LW'(w_first_cur + LW'(1)) : w_first_cur;
                        r_overflow   <= (r_overflow && !w_abandon)
                                        || (i_in.has_char && !w_first_room);
                        r_loading    <= i_in.end_of_name;
                        r_second_len <= '0;
                    end else if (w_sel_second) begin
                        if (i_in.has_char) begin
                            if (w_second_room) begin
                                r_second_len <= LW'(r_second_len + LW'(1));
                            end else begin
                                r_overflow <= 1'b1;
                            end
                        end
                        if (i_in.end_of_name) begin
                            r_state     <= ST_DRAIN;
                            r_drain_cnt <= '0;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (r_drain_cnt == CW'(MAX_LEN - 2)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_drain_cnt <= CW'(r_drain_cnt + CW'(1));
                    end
                end
                ST_DONE: begin
                    r_result.verdict    <= w_verdict;
                    r_result.common_run <= 9'(w_best[0]);
                    r_result.truncated  <= r_overflow;
                    r_strobe            <= 1'b1;
                    r_first_len         <= '0;
                    r_second_len        <= '0;
                    r_overflow          <= 1'b0;
                    r_loading           <= 1'b0;
                    r_state             <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== sv/hlcs_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hlcs_checker
// Port-level checks of the common substring test, bound to the top level.
// ---------------------------------------------------------------------------
`include "half_length_common_substring_test_macros.svh"

module hlcs_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input hlcs_pkg::t_in_beat   i_in,
    input logic                 o_strobe,
    input hlcs_pkg::t_out_beat  o_result
);

    // A result beat carries one of the three defined verdicts.
    `HLCS_ASSERT_IMP(a_verdict_code, i_clk, i_rst_n, o_strobe, (o_result.verdict == hlcs_pkg::VERDICT_SIMILAR || o_result.verdict == hlcs_pkg::VERDICT_DISSIMILAR || o_result.verdict == hlcs_pkg::VERDICT_TOO_SHORT), "result beat with an undefined verdict")

    // A result beat closes a busy drain and the block is ready while it shows.
    `HLCS_ASSERT_IMP(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, ($past(busy) && !busy), "result beat not preceded by a drain")

    // Two result beats never come back to back.
    `HLCS_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe, "two result beats in a row")

    // First-name beats never stall the input side.
    `HLCS_ASSERT_NXT(a_first_no_stall, i_clk, i_rst_n, (start && !busy && !i_in.name_select), !busy, "first-name beat made the block busy")

endmodule

bind half_length_common_substring_test hlcs_checker u_hlcs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_in     (i_in),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== sim/half_length_common_substring_test_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Half-length common substring test bench
// Streams pairs of names into the block beat by beat, predicts each verdict
// with a behavioral model of the matcher, and compares every result beat
// field by field. A short directed set is followed by random pairs, two
// overlong pairs and random gaps between input beats.
// ---------------------------------------------------------------------------
module half_length_common_substring_test_tb;

    localparam int   MAX_LEN     = 256;
    localparam int   BEAT_TARGET = 1250;
    localparam int   IDLE_LIMIT  = 8 * (MAX_LEN + 16);
    localparam logic SEL_FIRST   = 1'b0;
    localparam logic SEL_SECOND  = 1'b1;

    typedef logic [7:0] t_char_q [$];

    // One queued input beat; a set hold flag makes the driver wait until
    // every pending verdict has come back before it offers the beat.
    typedef struct {
        hlcs_pkg::t_in_beat beat;
        bit                 hold;
    } t_name_beat;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                start    = 1'b0;
    logic                busy;
    hlcs_pkg::t_in_beat  in_beat  = '0;
    logic                res_strobe;
    hlcs_pkg::t_out_beat res_beat;

    t_name_beat          name_beats[$];
    hlcs_pkg::t_out_beat pending_verdicts[$];

    // Matcher model state.
    logic [7:0] held_first [MAX_LEN];
    logic [8:0] run_len [MAX_LEN];
    int         first_cnt;
    int         second_cnt;
    int         longest;
    bit         cut_seen;
    bit         second_open;

    // Stimulus bookkeeping and run statistics.
    int  beat_total;
    bit  sprinkle;
    bit  pair_open;
    bit  steady;
    int  gap_left;
    int  error_count;
    int  idle_cycles;
    int  verdict_seen [3];
    int  cut_results;
    int  top_run;

    half_length_common_substring_test #(
        .MAX_LEN (MAX_LEN)
    ) u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (in_beat),
        .o_strobe (res_strobe),
        .o_result (res_beat)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Count and print one mismatch.
    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("mismatch in %s at %0t ns: got %0d, expected %0d", what, $time, got, want);
    endtask

    // Clear the per-pair state of the model.
    function automatic void restart_pair();
        first_cnt   = 0;
        second_cnt  = 0;
        longest     = 0;
        cut_seen    = 1'b0;
        second_open = 1'b0;
    endfunction

    // Advance the model by one accepted beat; a closed second name queues
    // the verdict that the block must give.
    function automatic void predict_verdict(hlcs_pkg::t_in_beat b);
        int                  shorter;
        int                  longer;
        int                  half;
        int                  v;
        logic [1:0]          code;
        hlcs_pkg::t_out_beat want;

        if (b.name_select == SEL_FIRST) begin
            if (second_open) begin
                restart_pair();
            end
            if (b.has_char) begin
                if (first_cnt < MAX_LEN) begin
                    held_first[first_cnt] = b.char_code;
                    first_cnt++;
                end else begin
                    cut_seen = 1'b1;
                end
            end
            if (b.end_of_name) begin
                second_open = 1'b1;
                second_cnt  = 0;
                longest     = 0;
                for (int k = 0; k < MAX_LEN; k++) begin
                    run_len[k] = '0;
                end
            end
            return;
        end

        // Second-name beats count only once the first name has ended.
        if (!second_open) begin
            return;
        end

        if (b.has_char) begin
            if (second_cnt >= MAX_LEN) begin
                cut_seen = 1'b1;
            end else begin
                second_cnt++;
                // Walk downward so that each cell still sees the old run
                // length of its left neighbor.
                for (int k = first_cnt - 1; k >= 0; k--) begin
                    if (held_first[k] == b.char_code) begin
                        v = ((k > 0) ? int'(run_len[k - 1]) : 0) + 1;
                        run_len[k] = v[8:0];
                        if (v > longest) begin
                            longest = v;
                        end
                    end else begin
                        run_len[k] = '0;
                    end
                end
            end
        end
        if (!b.end_of_name) begin
            return;
        end

        shorter = (first_cnt < second_cnt) ? first_cnt : second_cnt;
        longer  = (first_cnt < second_cnt) ? second_cnt : first_cnt;
        half    = (longer + 1) / 2;
        if (first_cnt == second_cnt && longest == first_cnt) begin
            code = hlcs_pkg::VERDICT_SIMILAR;
        end else if (half > shorter) begin
            code = hlcs_pkg::VERDICT_TOO_SHORT;
        end else if (longest >= half) begin
            code = hlcs_pkg::VERDICT_SIMILAR;
        end else begin
            code = hlcs_pkg::VERDICT_DISSIMILAR;
        end
        want.verdict     = code;
        want.common_run  = longest[8:0];
        want.truncated   = cut_seen;
        pending_verdicts = {pending_verdicts, want};
        restart_pair();
    endfunction

    // Gap before the next beat; steady stretches send back to back.
    function automatic int draw_gap();
        if ($urandom_range(0, 31) == 0) begin
            steady = !steady;
        end
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [7:0] pick_char(logic [7:0] base, int alpha);
        if (alpha >= 256) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'(base + $urandom_range(0, alpha - 1));
    endfunction

    task automatic push_beat(logic sel, logic has, logic [7:0] code, logic last,
                             bit hold, bit counted);
        t_name_beat nb;
        nb.beat.name_select = sel;
        nb.beat.has_char    = has;
        nb.beat.char_code   = code;
        nb.beat.end_of_name = last;
        nb.hold             = hold;
        name_beats          = {name_beats, nb};
        if (counted) begin
            beat_total++;
        end
    endtask

    // Queue one name; the end mark rides on the last character or on an
    // end-only beat of its own. An empty name with an end mark is a single end-only beat.
    task automatic push_name(logic sel, t_char_q chars, bit with_end, bit tail_end,
                             bit hold, bit counted);
        int n;
        bit held;
        n    = chars.size();
        held = hold;
        for (int i = 0; i < n; i++) begin
            if (sprinkle && $urandom_range(0, 19) == 0) begin
                push_beat(sel, 1'b0, 8'($urandom_range(0, 255)), 1'b0, held, counted);
                held = 1'b0;
            end
            push_beat(sel, 1'b1, chars[i], with_end && !tail_end && i == n - 1,
                      held, counted);
            held = 1'b0;
        end
        if (with_end && (tail_end || n == 0)) begin
            push_beat(sel, 1'b0, 8'($urandom_range(0, 255)), 1'b1, held, counted);
        end
    endtask

    task automatic send_pair(t_char_q a, t_char_q b, bit hold, bit abandon, bit counted);
        push_name(SEL_FIRST, a, 1'b1, $urandom_range(0, 3) == 0, hold, counted);
        push_name(SEL_SECOND, b, !abandon, $urandom_range(0, 3) == 0, 1'b0, counted);
        pair_open = abandon;
    endtask

    // One random pair: small alphabets make long common runs likely.
    task automatic queue_random_pair(bit hold);
        t_char_q    a;
        t_char_q    b;
        int         alpha;
        int         first_len;
        int         lo;
        int         hi;
        logic [7:0] base;
        bit         held;

        held = hold;
        case ($urandom_range(0, 2))
            0:       alpha = 2;
            1:       alpha = 4;
            default: alpha = 256;
        endcase
        base      = 8'($urandom_range(0, 255));
        first_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
        repeat (first_len) a = {a, pick_char(base, alpha)};

        case ($urandom_range(0, 4))
            0: b = a;
            1: begin
                b = a;
                if (b.size() > 0) begin
                    b[$urandom_range(0, b.size() - 1)] = pick_char(base, alpha);
                end
            end
            2: begin
                // A piece of the first name with random surroundings.
                lo = 0;
                hi = -1;
                if (a.size() > 0) begin
                    lo = $urandom_range(0, a.size() - 1);
                    hi = $urandom_range(lo, a.size() - 1);
                end
                repeat ($urandom_range(0, 3)) b = {b, pick_char(base, alpha)};
                for (int i = lo; i <= hi; i++) begin
                    b = {b, a[i]};
                end
                repeat ($urandom_range(0, 3)) b = {b, pick_char(base, alpha)};
            end
            3: repeat ($urandom_range(0, 12)) b = {b, pick_char(base, alpha)};
            default: begin
                lo = (a.size() > 1) ? $urandom_range(1, a.size() - 1) : 0;
                for (int i = lo; i < a.size(); i++) begin
                    b = {b, a[i]};
                end
            end
        endcase

        // Stray second-name beat while no first name has ended: ignored.
        if (!pair_open && $urandom_range(0, 9) == 0) begin
            push_beat(SEL_SECOND, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), held, 1'b0);
            held = 1'b0;
        end
        send_pair(a, b, held, $urandom_range(0, 15) == 0, 1'b1);
    endtask

    // Overlong pair: a twin pair cut on both sides, or a long first name
    // against a short second one.
    task automatic queue_long_pair(bit twin);
        t_char_q a;
        t_char_q b;
        int      n;
        n = twin ? MAX_LEN + 2 : $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
        repeat (n) a = {a, 8'($urandom_range(0, 255))};
        if (twin) begin
            b = a;
        end else begin
            repeat ($urandom_range(1, 6)) b = {b, 8'($urandom_range(0, 255))};
        end
        send_pair(a, b, 1'b0, 1'b0, 1'b1);
    endtask

    // Driver: offers queued beats with random gaps, holds a beat while busy.
    always @(posedge clk) begin : drive
        bit took;
        if (!rst_n) begin
            start    <= 1'b0;
            gap_left  = 0;
        end else begin
            took = start && !busy;
            if (took) begin
                predict_verdict(in_beat);
                gap_left = draw_gap();
            end
            if (start && !took) begin
                // Beat still waiting for the block.
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (name_beats.size() > 0
                         && (!name_beats[0].hold || pending_verdicts.size() == 0)) begin
                in_beat <= name_beats[0].beat;
                start   <= 1'b1;
                void'(name_beats.pop_front());
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every result beat is checked against the oldest prediction.
    always @(posedge clk) begin : watch_results
        hlcs_pkg::t_out_beat want;
        if (rst_n && res_strobe) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result verdict", int'(res_beat.verdict), -1);
            end else begin
                want = pending_verdicts.pop_front();
                if (res_beat.verdict !== want.verdict) begin
                    report_mismatch("verdict", int'(res_beat.verdict), int'(want.verdict));
                end
                if (res_beat.common_run !== want.common_run) begin
                    report_mismatch("common_run", int'(res_beat.common_run),
                                    int'(want.common_run));
                end
                if (res_beat.truncated !== want.truncated) begin
                    report_mismatch("truncated", int'(res_beat.truncated),
                                    int'(want.truncated));
                end
                verdict_seen[want.verdict]++;
                cut_results += int'(want.truncated);
                if (int'(want.common_run) > top_run) begin
                    top_run = int'(want.common_run);
                end
            end
        end
    end

    // Cycles in which no beat moves on either side.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || res_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        t_char_q a;
        t_char_q b;
        int      long_at0;
        int      long_at1;
        int      pair_idx;

        restart_pair();
        for (int k = 0; k < MAX_LEN; k++) begin
            run_len[k] = '0;
        end

        // Directed: two empty names are equal, hence similar.
        sprinkle = 1'b0;
        send_pair(a, b, 1'b0, 1'b0, 1'b1);
        // Equal names at the extreme byte values.
        a = '{8'h00, 8'hFF};
        b = '{8'h00, 8'hFF};
        send_pair(a, b, 1'b0, 1'b0, 1'b1);
        // Shorter name below half the longer length.
        a = '{8'h61, 8'h62, 8'h63, 8'h64};
        b = '{8'h61};
        send_pair(a, b, 1'b0, 1'b0, 1'b1);
        // Nothing in common, second name closed by an end-only beat.
        a = '{8'h01, 8'h02, 8'h03};
        b = '{8'h04, 8'h05, 8'h06};
        push_name(SEL_FIRST, a, 1'b1, 1'b0, 1'b0, 1'b1);
        push_name(SEL_SECOND, b, 1'b1, 1'b1, 1'b0, 1'b1);
        // Second-name beat with no first name ended is ignored.
        push_beat(SEL_SECOND, 1'b1, 8'hA5, 1'b1, 1'b0, 1'b0);
        // A first-name beat during the second name abandons the pair.
        a = '{8'h78, 8'h79};
        b = '{8'h78};
        send_pair(a, b, 1'b0, 1'b1, 1'b1);
        a = '{8'h78, 8'h79, 8'h7A};
        b = '{8'h79, 8'h7A};
        send_pair(a, b, 1'b1, 1'b0, 1'b1);

        // Random pairs, with two overlong pairs placed early at random.
        sprinkle = 1'b1;
        long_at0 = $urandom_range(2, 10);
        long_at1 = $urandom_range(11, 20);
        pair_idx = 0;
        while (beat_total < BEAT_TARGET) begin
            if (pair_idx == long_at0 || pair_idx == long_at1) begin
                queue_long_pair(pair_idx == long_at0);
            end
            queue_random_pair(pair_idx == 0 || $urandom_range(0, 11) == 0);
            pair_idx++;
        end
        // Close any pair left open so that the run ends on a verdict.
        a = '{8'h30};
        b = '{8'h30};
        send_pair(a, b, 1'b0, 1'b0, 1'b1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (name_beats.size() > 0 || start) begin
            @(posedge clk);
        end
        while (pending_verdicts.size() > 0) begin
            @(posedge clk);
        end
        repeat (MAX_LEN + 16) @(posedge clk);

        $display("sent %0d counted beats in %0d random pairs; verdicts similar %0d, "
                 , beat_total, pair_idx, verdict_seen[hlcs_pkg::VERDICT_SIMILAR]);
        $display("dissimilar %0d, too short %0d, truncated %0d, longest run %0d",
                 verdict_seen[hlcs_pkg::VERDICT_DISSIMILAR],
                 verdict_seen[hlcs_pkg::VERDICT_TOO_SHORT], cut_results, top_run);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
